[rtl/gtp_pkg.sv]
// ----------------------------------------------------------------------------
// gtp_pkg
// Shared codes, constants and the CORDIC arctangent table of the go-to-pose controller.
// ----------------------------------------------------------------------------
`default_nettype none

package gtp_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;
  localparam int IDX_W            = 5;

  localparam int POS_W  = 24;
  localparam int DIFF_W = 25;
  localparam int ANG_W  = 16;
  localparam int TOL_W  = 20;
  localparam int SPD_W  = 15;
  localparam int CFG_W  = 20;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] ACT_GOAL   = 2'd0;
  localparam logic [1:0] ACT_TICK   = 2'd1;
  localparam logic [1:0] ACT_CANCEL = 2'd2;

  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_BUSY     = 2'd1;
  localparam logic [1:0] ST_SUCCEED  = 2'd2;
  localparam logic [1:0] ST_CANCELED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_POS_TOL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HDG_TOL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FWD_SPD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_LIM = 2'd3;

  localparam logic [TOL_W-1:0] POS_TOL_RST  = 20'd4915;
  localparam logic [SPD_W-1:0] HDG_TOL_RST  = 15'd1820;
  localparam logic [SPD_W-1:0] FWD_SPD_RST  = 15'd410;
  localparam logic [SPD_W-1:0] TURN_LIM_RST = 15'd4096;

  // About pi/8 per binary angle unit, scaled by 65536.
  localparam logic [15:0] RATE_GAIN  = 16'd25736;
  localparam logic [31:0] RATE_ROUND = 32'd32768;

  // Arctangent of 2^-i in binary angle units, pi = 32768.
  function automatic logic [ANG_W-1:0] atan_bau(input logic [IDX_W-1:0] idx);
    logic [ANG_W-1:0] v;
    case (idx)
      5'd0:    v = 16'd8192;
      5'd1:    v = 16'd4836;
      5'd2:    v = 16'd2555;
      5'd3:    v = 16'd1297;
      5'd4:    v = 16'd651;
      5'd5:    v = 16'd326;
      5'd6:    v = 16'd163;
      5'd7:    v = 16'd81;
      5'd8:    v = 16'd41;
      5'd9:    v = 16'd20;
      5'd10:   v = 16'd10;
      5'd11:   v = 16'd5;
      5'd12:   v = 16'd3;
      5'd13:   v = 16'd1;
      5'd14:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/gtp_in_if.sv]
// ----------------------------------------------------------------------------
// gtp_in_if
// Input channel: goal, tick and cancel transactions with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface gtp_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [23:0] goal_x;
  logic signed [23:0] goal_y;
  logic signed [15:0] goal_heading;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic signed [15:0] heading;

  modport source (
    output valid, action, goal_x, goal_y, goal_heading, pos_x, pos_y, heading,
    input  ready
  );
  modport sink (
    input  valid, action, goal_x, goal_y, goal_heading, pos_x, pos_y, heading,
    output ready
  );
endinterface

`default_nettype wire

[rtl/gtp_out_if.sv]
// ----------------------------------------------------------------------------
// gtp_out_if
// Result channel: velocity command and status transactions with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface gtp_out_if;
  logic               valid;
  logic               ready;
  logic               cmd_valid;
  logic [14:0]        linear_cmd;
  logic signed [15:0] angular_cmd;
  logic [1:0]         status;

  modport source (
    output valid, cmd_valid, linear_cmd, angular_cmd, status,
    input  ready
  );
  modport sink (
    input  valid, cmd_valid, linear_cmd, angular_cmd, status,
    output ready
  );
endinterface

`default_nettype wire

[rtl/gtp_cordic.sv]
// ----------------------------------------------------------------------------
// gtp_cordic
// Iterative vectoring CORDIC that returns the bearing of (dx, dy) in binary
// angle units, one micro-rotation per clock cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gtp_cordic #(
  parameter int STEPS = gtp_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic signed [gtp_pkg::DIFF_W-1:0]  dx,
  input  wire logic signed [gtp_pkg::DIFF_W-1:0]  dy,
  output logic                                    done,
  output logic [gtp_pkg::ANG_W-1:0]               angle
);

  localparam int NSTEPS = (STEPS > gtp_pkg::ATAN_LEN) ? gtp_pkg::ATAN_LEN : STEPS;
  localparam logic [gtp_pkg::IDX_W-1:0] LAST = gtp_pkg::IDX_W'(NSTEPS - 1);
  localparam int XW = gtp_pkg::DIFF_W + 3;

  logic signed [XW-1:0]            x_r, y_r;
  logic [gtp_pkg::ANG_W-1:0]       z_r;
  logic [gtp_pkg::IDX_W-1:0]       i_r;
  logic                            busy_r, done_r;

  logic signed [XW-1:0] dx_ext, dy_ext, xs, ys;

  assign dx_ext = XW'(dx);
  assign dy_ext = XW'(dy);
  assign xs     = x_r >>> i_r;
  assign ys     = y_r >>> i_r;
  assign done   = done_r;
  assign angle  = z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        i_r <= '0;
        if (dx == '0 && dy == '0) begin
          z_r    <= '0;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          if (dx < 0) begin
            x_r <= -dx_ext;
            y_r <= -dy_ext;
            z_r <= 16'h8000;
          end else begin
            x_r <= dx_ext;
            y_r <= dy_ext;
            z_r <= '0;
          end
        end
      end else if (busy_r) begin
        if (y_r > 0) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + gtp_pkg::atan_bau(i_r);
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - gtp_pkg::atan_bau(i_r);
        end
        if (i_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          i_r <= i_r + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/go_to_pose_controller_core.sv]
// ----------------------------------------------------------------------------
// go_to_pose_controller_core
// Two-phase go-to-pose controller: drive toward a goal point, then turn to
// the goal heading, with cancel support and a plain configuration port.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time and is not ready while it works
// on one. A new goal, a cancel and a tick while idle produce their result
// directly; a tick while aligning checks the heading error first and, when
// it is outside the tolerance, turns it into a turn rate. A tick while
// moving takes the position differences, makes three passes through one
// shared 25 x 25 multiplier for the squared distance and tolerance, runs
// one CORDIC micro-rotation per cycle for the bearing, and makes one more
// multiplier pass to turn the angle error into a turn rate. The tick
// on which the goal point is reached produces no result. A finished result
// waits in the output register while the next transaction is accepted; if
// that register is still full when the next result is ready, the block
// waits until the result side takes it.
`default_nettype none

module go_to_pose_controller_core #(
  parameter int CORDIC_STEPS = gtp_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  gtp_in_if.sink                                 in_chan,
  gtp_out_if.source                              out_chan,
  input  wire logic                              cfg_we,
  input  wire logic [gtp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [gtp_pkg::CFG_W-1:0]         cfg_wdata
);

  typedef enum logic [1:0] {PH_IDLE, PH_MOVE, PH_ALIGN} phase_t;
  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_SQX, S_SQY, S_SQT, S_CMP, S_CORD, S_ALGN, S_RATE, S_CLAMP, S_DONE
  } state_t;

  localparam int MW = gtp_pkg::DIFF_W;

  state_t state_r;
  phase_t phase_r;

  logic [gtp_pkg::TOL_W-1:0] pos_tol_r;
  logic [gtp_pkg::SPD_W-1:0] hdg_tol_r, fwd_spd_r, turn_lim_r;

  logic signed [gtp_pkg::POS_W-1:0]  tgt_x_r, tgt_y_r, px_r, py_r;
  logic signed [gtp_pkg::ANG_W-1:0]  tgt_hd_r, hd_r, err_r;
  logic signed [gtp_pkg::DIFF_W-1:0] dx_r, dy_r;
  logic [2*MW-1:0]                   prod_r, acc_r;

  logic                       res_cmd_r;
  logic [gtp_pkg::SPD_W-1:0]  res_lin_r;
  logic [gtp_pkg::ANG_W-1:0]  res_ang_r;
  logic [1:0]                 res_st_r;

  logic                       out_valid_r, out_cmd_r;
  logic [gtp_pkg::SPD_W-1:0]  out_lin_r;
  logic [gtp_pkg::ANG_W-1:0]  out_ang_r;
  logic [1:0]                 out_st_r;

  logic                       accept, close, cord_start, cord_done;
  logic [gtp_pkg::ANG_W-1:0]  cord_angle;
  logic [MW-1:0]              ax, ay, mul_a, mul_b;
  logic [gtp_pkg::ANG_W-1:0]  err_mag, algn_err, algn_mag;
  logic [31:0]                rnd;
  logic [15:0]                rate, rate_clamped;

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;

  assign out_chan.valid       = out_valid_r;
  assign out_chan.cmd_valid   = out_cmd_r;
  assign out_chan.linear_cmd  = out_lin_r;
  assign out_chan.angular_cmd = out_ang_r;
  assign out_chan.status      = out_st_r;

  assign ax = dx_r[MW-1] ? MW'(-dx_r) : MW'(dx_r);
  assign ay = dy_r[MW-1] ? MW'(-dy_r) : MW'(dy_r);
  assign err_mag  = err_r[gtp_pkg::ANG_W-1] ? gtp_pkg::ANG_W'(-err_r) : err_r;
  assign algn_err = tgt_hd_r - hd_r;
  assign algn_mag = algn_err[gtp_pkg::ANG_W-1] ? gtp_pkg::ANG_W'(-algn_err) : algn_err;

  assign close      = acc_r < prod_r;
  assign cord_start = (state_r == S_CMP) && !close;

  assign rnd          = prod_r[31:0] + gtp_pkg::RATE_ROUND;
  assign rate         = rnd[31:16];
  assign rate_clamped = (rate > {1'b0, turn_lim_r}) ? {1'b0, turn_lim_r} : rate;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SQX: begin
        mul_a = ax;
        mul_b = ax;
      end
      S_SQY: begin
        mul_a = ay;
        mul_b = ay;
      end
      S_SQT: begin
        mul_a = MW'(pos_tol_r);
        mul_b = MW'(pos_tol_r);
      end
      S_RATE: begin
        mul_a = MW'(err_mag);
        mul_b = MW'(gtp_pkg::RATE_GAIN);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  gtp_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .dx    (dx_r),
    .dy    (dy_r),
    .done  (cord_done),
    .angle (cord_angle)
  );

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_tol_r  <= gtp_pkg::POS_TOL_RST;
      hdg_tol_r  <= gtp_pkg::HDG_TOL_RST;
      fwd_spd_r  <= gtp_pkg::FWD_SPD_RST;
      turn_lim_r <= gtp_pkg::TURN_LIM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gtp_pkg::CFG_POS_TOL:  pos_tol_r  <= cfg_wdata;
        gtp_pkg::CFG_HDG_TOL:  hdg_tol_r  <= cfg_wdata[gtp_pkg::SPD_W-1:0];
        gtp_pkg::CFG_FWD_SPD:  fwd_spd_r  <= cfg_wdata[gtp_pkg::SPD_W-1:0];
        gtp_pkg::CFG_TURN_LIM: turn_lim_r <= cfg_wdata[gtp_pkg::SPD_W-1:0];
        default:               pos_tol_r  <= pos_tol_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_IDLE;
      tgt_x_r     <= '0;
      tgt_y_r     <= '0;
      tgt_hd_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_chan.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            res_cmd_r <= 1'b0;
            res_lin_r <= '0;
            res_ang_r <= '0;
            case (in_chan.action)
              gtp_pkg::ACT_GOAL: begin
                tgt_x_r  <= in_chan.goal_x;
                tgt_y_r  <= in_chan.goal_y;
                tgt_hd_r <= in_chan.goal_heading;
                phase_r  <= PH_MOVE;
                res_st_r <= gtp_pkg::ST_BUSY;
                state_r  <= S_DONE;
              end
              gtp_pkg::ACT_CANCEL: begin
                res_st_r <= (phase_r == PH_IDLE) ? gtp_pkg::ST_IDLE : gtp_pkg::ST_CANCELED;
                phase_r  <= PH_IDLE;
                state_r  <= S_DONE;
              end
              gtp_pkg::ACT_TICK: begin
                px_r <= in_chan.pos_x;
                py_r <= in_chan.pos_y;
                hd_r <= in_chan.heading;
                case (phase_r)
                  PH_MOVE:  state_r <= S_DIFF;
                  PH_ALIGN: state_r <= S_ALGN;
                  default: begin
                    phase_r  <= PH_IDLE;
                    res_st_r <= gtp_pkg::ST_IDLE;
                    state_r  <= S_DONE;
                  end
                endcase
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_DIFF: begin
          dx_r    <= {tgt_x_r[gtp_pkg::POS_W-1], tgt_x_r} - {px_r[gtp_pkg::POS_W-1], px_r};
          dy_r    <= {tgt_y_r[gtp_pkg::POS_W-1], tgt_y_r} - {py_r[gtp_pkg::POS_W-1], py_r};
          state_r <= S_SQX;
        end
        S_SQX: state_r <= S_SQY;
        S_SQY: begin
          acc_r   <= prod_r;
          state_r <= S_SQT;
        end
        S_SQT: begin
          acc_r   <= acc_r + prod_r;
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (close) begin
            phase_r <= PH_ALIGN;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_CORD;
          end
        end
        S_CORD: begin
          if (cord_done) begin
            err_r     <= cord_angle - hd_r;
            res_lin_r <= fwd_spd_r;
            state_r   <= S_RATE;
          end
        end
        S_ALGN: begin
          res_lin_r <= '0;
          if (algn_mag <= {1'b0, hdg_tol_r}) begin
            phase_r   <= PH_IDLE;
            res_cmd_r <= 1'b1;
            res_ang_r <= '0;
            res_st_r  <= gtp_pkg::ST_SUCCEED;
            state_r   <= S_DONE;
          end else begin
            err_r   <= algn_err;
            state_r <= S_RATE;
          end
        end
        S_RATE: state_r <= S_CLAMP;
        S_CLAMP: begin
          res_cmd_r <= 1'b1;
          res_ang_r <= err_r[gtp_pkg::ANG_W-1] ? gtp_pkg::ANG_W'(-rate_clamped) : rate_clamped;
          res_st_r  <= gtp_pkg::ST_BUSY;
          state_r   <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r <= 1'b1;
            out_cmd_r   <= res_cmd_r;
            out_lin_r   <= res_lin_r;
            out_ang_r   <= res_ang_r;
            out_st_r    <= res_st_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
